### rtl/core/dccs_pkg.sv
`timescale 1ns / 1ps

package dccs_pkg;

    localparam int unsigned XY_W    = 24;
    localparam int unsigned Z_W     = 21;
    localparam int unsigned CFG_W   = 20;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned TENTH_W = 17;

    // Floor of x / 10 for any x below 2**22 is (x * TENTH_MUL) >> TENTH_SHIFT.
    localparam int unsigned     TENTH_SHIFT      = 23;
    localparam logic [CFG_W-1:0] TENTH_MUL       = 20'd838861;
    localparam logic [CFG_W-1:0] DEFAULT_MIN_STEP = 20'd1000;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE,
        REG_DEPTH,
        REG_RETRACT,
        REG_PECK
    } t_reg;

    typedef enum logic [3:0] {
        PC_IDLE,
        PC_ENTRY,
        PC_CHECK,
        PC_FIX,
        PC_TENTH,
        PC_TENTH2,
        PC_FIRST,
        PC_FEED,
        PC_RETR,
        PC_RETN,
        PC_SBOT,
        PC_SRET
    } t_pc;

    typedef enum logic [1:0] {
        Z_RETRACT,
        Z_BOTTOM,
        Z_FEED,
        Z_RETURN
    } t_zsel;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_STEP0,
        ACT_CHECK,
        ACT_FIX,
        ACT_TENTH,
        ACT_TENTH2,
        ACT_ADVANCE
    } t_act;

    typedef enum logic [1:0] {
        LAST_NO,
        LAST_YES,
        LAST_EMPTY,
        LAST_DONE
    } t_last;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_SIMPLE,
        J_EMPTY,
        J_DONE
    } t_jcond;

    typedef struct packed {
        logic   emit;
        t_zsel  zsel;
        t_act   act;
        t_last  last;
        t_jcond jcond;
        t_pc    target;
    } t_uword;

    // Control store of the drilling program.
    function automatic t_uword f_ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:   w = '{1'b0, Z_RETRACT, ACT_NONE,    LAST_NO,    J_NEXT,   PC_IDLE};
            PC_ENTRY:  w = '{1'b1, Z_RETRACT, ACT_STEP0,   LAST_EMPTY, J_SIMPLE, PC_SBOT};
            PC_CHECK:  w = '{1'b0, Z_RETRACT, ACT_CHECK,   LAST_NO,    J_EMPTY,  PC_IDLE};
            PC_FIX:    w = '{1'b0, Z_RETRACT, ACT_FIX,     LAST_NO,    J_NEXT,   PC_IDLE};
            PC_TENTH:  w = '{1'b0, Z_RETRACT, ACT_TENTH,   LAST_NO,    J_NEXT,   PC_IDLE};
            PC_TENTH2: w = '{1'b0, Z_RETRACT, ACT_TENTH2,  LAST_NO,    J_NEXT,   PC_IDLE};
            PC_FIRST:  w = '{1'b0, Z_RETRACT, ACT_ADVANCE, LAST_NO,    J_NEXT,   PC_IDLE};
            PC_FEED:   w = '{1'b1, Z_FEED,    ACT_NONE,    LAST_NO,    J_NEXT,   PC_IDLE};
            PC_RETR:   w = '{1'b1, Z_RETRACT, ACT_NONE,    LAST_DONE,  J_DONE,   PC_IDLE};
            PC_RETN:   w = '{1'b1, Z_RETURN,  ACT_ADVANCE, LAST_NO,    J_ALWAYS, PC_FEED};
            PC_SBOT:   w = '{1'b1, Z_BOTTOM,  ACT_NONE,    LAST_NO,    J_NEXT,   PC_IDLE};
            PC_SRET:   w = '{1'b1, Z_RETRACT, ACT_NONE,    LAST_YES,   J_ALWAYS, PC_IDLE};
            default:   w = '{1'b0, Z_RETRACT, ACT_NONE,    LAST_NO,    J_ALWAYS, PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

### rtl/core/drill_canned_cycle_sequencer.sv
`timescale 1ns / 1ps

// Drill canned-cycle sequencer. Each input word is one hole position (X, Y);
// the block answers with the motion points of a drilling cycle for that hole,
// one output word per point, with last_point set on the final point.
// Input channel: i_valid / o_stall, accepted when i_valid is high and o_stall
// low. Output channel: o_valid / i_stall, taken when o_valid is high and
// i_stall low. Configuration: i_cfg_valid / o_cfg_ready with a register index
// (0 mode, 1 depth, 2 retract height, 3 peck step); o_cfg_ready is always high.
// Sequence: an accepted hole sends the program to its entry step, which loads
// the first point into the output register. A simple cycle emits three points
// and one idle step. A peck cycle runs setup and the first peck, a return,
// feed and retract step per further peck and one idle step; the default peck
// hole takes four pecks. The microprogram emits at most one point per step and
// sizes the step in its entry, check and fix steps through one multiplier stage.
// When the receiver stalls, the pending point holds in the output register and
// the program waits on its emit step. A new hole is taken as soon as the
// program returns to idle, even while the final point still waits.
// Synchronous reset returns the program to idle, drops o_valid and restores the
// register defaults: simple mode, depth 5000, retract 2000, default peck step.
module drill_canned_cycle_sequencer
    import dccs_pkg::*;
#(
    parameter int unsigned MAX_PECKS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Hole input channel.
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [XY_W-1:0]  i_hole_x,
    input  logic signed [XY_W-1:0]  i_hole_y,
    // Motion point output channel.
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [XY_W-1:0]  o_point_x,
    output logic signed [XY_W-1:0]  o_point_y,
    output logic signed [Z_W-1:0]   o_point_z,
    output logic                    o_last_point,
    // Configuration write channel.
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    // The peck-count limit is checked as depth > step * MAX_PECKS, which is the
    // same as ceil(depth / step) > MAX_PECKS. The raised step,
    // ceil(depth / MAX_PECKS), comes from a reciprocal multiply that is exact
    // for every numerator below 2**21.
    localparam int unsigned PK_W      = $clog2(MAX_PECKS + 1);
    localparam int unsigned LIM_W     = CFG_W + PK_W;
    localparam int unsigned DIV_SHIFT = 26;
    localparam int unsigned DIV_MUL   = ((2 ** DIV_SHIFT) + MAX_PECKS - 1) / MAX_PECKS;
    localparam int unsigned MUL_W     = $clog2(DIV_MUL + 1);
    localparam int unsigned QP_W      = (CFG_W + 1 + MUL_W > DIV_SHIFT + CFG_W) ?
                                        (CFG_W + 1 + MUL_W) : (DIV_SHIFT + CFG_W);
    localparam int unsigned TP_W      = 2 * CFG_W;

    // Configuration registers.
    logic              r_mode;
    logic [CFG_W-1:0]  r_hole_depth;
    logic [CFG_W-1:0]  r_retract;
    logic [CFG_W-1:0]  r_peck;

    // Sequencer and datapath.
    t_pc               r_pc, n_pc;
    logic [XY_W-1:0]   r_hole_x, r_hole_y;
    logic [CFG_W-1:0]  r_step, n_step;
    logic [CFG_W-1:0]  r_cur, n_cur;
    logic [LIM_W-1:0]  r_lim, n_lim;
    logic [QP_W-1:0]   r_qprod, n_qprod;
    logic [TP_W-1:0]   r_tprod, n_tprod;
    logic [TENTH_W-1:0] r_tenth, n_tenth;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic [XY_W-1:0]   r_out_x, r_out_y;
    logic [Z_W-1:0]    r_out_z, n_out_z;
    logic              r_out_last, n_out_last;

    t_uword            u;
    logic              in_accept;
    logic              out_free;
    logic              go;
    logic              emit_now;
    logic              done;
    logic              empty;
    logic              jump;
    logic [CFG_W-1:0]  quarter;
    logic [CFG_W-1:0]  step0;
    logic [CFG_W:0]    ceil_num;
    logic [CFG_W:0]    adv_sum;
    logic [Z_W-1:0]    z_val;
    logic              last_val;

    assign u         = f_ucode(r_pc);
    assign o_stall   = (r_pc != PC_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    // A compute step always proceeds; an emit step waits for a free output slot.
    assign go        = (r_pc != PC_IDLE) && (!u.emit || out_free);
    assign emit_now  = go && u.emit;
    assign done      = (r_cur >= r_hole_depth);
    assign empty     = (r_hole_depth == '0);

    assign quarter   = r_hole_depth >> 2;
    assign step0     = (r_peck != '0) ? r_peck :
                       ((quarter < DEFAULT_MIN_STEP) ? DEFAULT_MIN_STEP : quarter);
    assign ceil_num  = {1'b0, r_hole_depth} + (CFG_W + 1)'(MAX_PECKS - 1);
    assign adv_sum   = {1'b0, r_cur} + {1'b0, r_step};

    always_comb begin
        unique case (u.zsel)
            Z_RETRACT: z_val = Z_W'({1'b0, r_retract});
            Z_BOTTOM:  z_val = Z_W'(0) - Z_W'({1'b0, r_hole_depth});
            Z_FEED:    z_val = Z_W'(0) - Z_W'({1'b0, r_cur});
            Z_RETURN:  z_val = Z_W'(r_tenth) - Z_W'({1'b0, r_cur});
            default:   z_val = '0;
        endcase
    end

    always_comb begin
        unique case (u.last)
            LAST_NO:    last_val = 1'b0;
            LAST_YES:   last_val = 1'b1;
            LAST_EMPTY: last_val = r_mode && empty;
            LAST_DONE:  last_val = done;
            default:    last_val = 1'b0;
        endcase
    end

    always_comb begin
        unique case (u.jcond)
            J_NEXT:   jump = 1'b0;
            J_ALWAYS: jump = 1'b1;
            J_SIMPLE: jump = !r_mode;
            J_EMPTY:  jump = empty;
            J_DONE:   jump = done;
            default:  jump = 1'b0;
        endcase
    end

    always_comb begin
        n_pc        = r_pc;
        n_step      = r_step;
        n_cur       = r_cur;
        n_lim       = r_lim;
        n_qprod     = r_qprod;
        n_tprod     = r_tprod;
        n_tenth     = r_tenth;
        n_out_valid = r_out_valid && i_stall;
        n_out_z     = r_out_z;
        n_out_last  = r_out_last;

        if (in_accept) begin
            n_pc  = PC_ENTRY;
            n_cur = '0;
        end else if (go) begin
            n_pc = jump ? u.target : t_pc'(r_pc + 4'd1);
            unique case (u.act)
                ACT_NONE:    ;
                ACT_STEP0:   n_step = step0;
                ACT_CHECK: begin
                    n_lim   = LIM_W'(r_step) * LIM_W'(MAX_PECKS);
                    n_qprod = QP_W'(ceil_num) * QP_W'(DIV_MUL);
                end
                ACT_FIX: begin
                    if (LIM_W'(r_hole_depth) > r_lim) begin
                        n_step = r_qprod[DIV_SHIFT +: CFG_W];
                    end
                end
                ACT_TENTH:   n_tprod = TP_W'(r_step) * TP_W'(TENTH_MUL);
                ACT_TENTH2:  n_tenth = r_tprod[TENTH_SHIFT +: TENTH_W];
                ACT_ADVANCE: begin
                    n_cur = (adv_sum > {1'b0, r_hole_depth}) ? r_hole_depth
                                                             : adv_sum[CFG_W-1:0];
                end
                default:     ;
            endcase
        end

        if (emit_now) begin
            n_out_valid = 1'b1;
            n_out_z     = z_val;
            n_out_last  = last_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= PC_IDLE;
            r_out_valid  <= 1'b0;
            r_mode       <= 1'b0;
            r_hole_depth <= 20'd5000;
            r_retract    <= 20'd2000;
            r_peck       <= '0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_reg'(i_cfg_index))
                    REG_MODE:    r_mode       <= i_cfg_data[0];
                    REG_DEPTH:   r_hole_depth <= i_cfg_data;
                    REG_RETRACT: r_retract    <= i_cfg_data;
                    REG_PECK:    r_peck       <= i_cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_hole_x <= i_hole_x;
            r_hole_y <= i_hole_y;
        end
        if (emit_now) begin
            r_out_x <= r_hole_x;
            r_out_y <= r_hole_y;
        end
        r_step     <= n_step;
        r_cur      <= n_cur;
        r_lim      <= n_lim;
        r_qprod    <= n_qprod;
        r_tprod    <= n_tprod;
        r_tenth    <= n_tenth;
        r_out_z    <= n_out_z;
        r_out_last <= n_out_last;
    end

    assign o_valid      = r_out_valid;
    assign o_point_x    = r_out_x;
    assign o_point_y    = r_out_y;
    assign o_point_z    = r_out_z;
    assign o_last_point = r_out_last;
    assign o_cfg_ready  = 1'b1;

    // The depth reached never passes the hole bottom while a hole is in work.
    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc != PC_IDLE) |-> (r_cur <= r_hole_depth))
        else $error("depth reached exceeds hole depth");

    // A feed point always follows a real advance by a nonzero step.
    a_feed_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_FEED) |-> ((r_step != '0) && (r_cur != '0)))
        else $error("feed point without a nonzero step");

    // A new point is only loaded by an emit step of the program.
    a_point_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_pc) != PC_IDLE))
        else $error("output word loaded while idle");

endmodule

### tb/drill_canned_cycle_sequencer_tb.sv
`timescale 1ns / 1ps

// The hole input and the motion point output both use valid/stall. A word
// moves on a rising edge where valid is high and stall is low. All inputs
// change on the falling edge and all outputs are sampled on the rising edge,
// so nothing here depends on the order of events within one time step.
module drill_canned_cycle_sequencer_tb
    import dccs_pkg::*;
();

    localparam int unsigned PECK_LIMIT      = 16;
    localparam int unsigned IDLE_PCT        = 26;
    localparam int unsigned CYCLE_LIMIT     = 500000;
    localparam int unsigned RANDOM_PHASES   = 10;
    localparam int unsigned HOLES_PER_PHASE = 24;
    localparam int unsigned STEADY_PHASE    = 4;

    typedef struct {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
    } t_hole;

    typedef struct {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   last;
    } t_motion_point;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_valid      = 1'b0;
    logic                   o_stall;
    logic signed [XY_W-1:0] i_hole_x     = '0;
    logic signed [XY_W-1:0] i_hole_y     = '0;
    logic                   o_valid;
    logic                   i_stall      = 1'b0;
    logic signed [XY_W-1:0] o_point_x;
    logic signed [XY_W-1:0] o_point_y;
    logic signed [Z_W-1:0]  o_point_z;
    logic                   o_last_point;
    logic                   i_cfg_valid  = 1'b0;
    logic                   o_cfg_ready;
    logic [IDX_W-1:0]       i_cfg_index  = '0;
    logic [CFG_W-1:0]       i_cfg_data   = '0;

    // Holes waiting to be driven, and the motion points the drilling program
    // owes for holes already accepted, oldest first.
    t_hole          holes_waiting[$];
    t_motion_point  points_owed[$];

    // Shadow copy of the cycle registers, updated on every accepted write.
    logic             cyc_mode;
    logic [CFG_W-1:0] cyc_depth;
    logic [CFG_W-1:0] cyc_retract;
    logic [CFG_W-1:0] cyc_peck;

    int  holes_queued   = 0;
    int  holes_accepted = 0;
    int  fault_count    = 0;
    int  cycle_count    = 0;
    logic hole_taken    = 1'b0;
    // While set, neither side inserts idle cycles.
    bit  steady         = 1'b0;

    drill_canned_cycle_sequencer #(
        .MAX_PECKS(PECK_LIMIT)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hole_x     (i_hole_x),
        .i_hole_y     (i_hole_y),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y),
        .o_point_z    (o_point_z),
        .o_last_point (o_last_point),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Appends one motion point to the list of points owed.
    function automatic void owe_point(input logic signed [XY_W-1:0] hx,
                                      input logic signed [XY_W-1:0] hy,
                                      input longint zval);
        t_motion_point pt;
        pt.x    = hx;
        pt.y    = hy;
        pt.z    = zval[Z_W-1:0];
        pt.last = 1'b0;
        points_owed = {points_owed, pt};
    endfunction

    // Works out the whole drilling cycle for one hole under the current
    // register settings. The first point is always the retract plane. A simple
    // cycle goes to the bottom and back up. A peck cycle feeds down one step
    // at a time, clamped at the bottom, retracting after every peck and
    // re-entering a tenth of a step above the last depth until the bottom
    // is reached.
    function automatic void plan_drill_cycle(input logic signed [XY_W-1:0] hx,
                                             input logic signed [XY_W-1:0] hy);
        longint        depth;
        longint        lift;
        longint        step;
        longint        reach;
        t_motion_point pt;
        depth = longint'(cyc_depth);
        lift  = longint'(cyc_retract);
        reach = 0;
        owe_point(hx, hy, lift);
        if (!cyc_mode) begin
            owe_point(hx, hy, -depth);
            owe_point(hx, hy, lift);
        end else begin
            if (cyc_peck != '0) begin
                step = longint'(cyc_peck);
            end else begin
                step = depth / 4;
                if (step < 1000) begin
                    step = 1000;
                end
            end
            // Too many pecks: widen the step so the hole takes the limit.
            if ((depth + step - 1) / step > PECK_LIMIT) begin
                step = (depth + PECK_LIMIT - 1) / PECK_LIMIT;
            end
            while (reach < depth) begin
                reach = reach + step;
                if (reach > depth) begin
                    reach = depth;
                end
                owe_point(hx, hy, -reach);
                owe_point(hx, hy, lift);
                if (reach >= depth) begin
                    break;
                end
                owe_point(hx, hy, -reach + step / 10);
            end
        end
        // The final point owed is marked last; a zero-depth peck hole ends on its very first point.
        pt = points_owed.pop_back();
        pt.last = 1'b1;
        points_owed = {points_owed, pt};
    endfunction

    // Hole driver. A new word is offered only once the previous one has been
    // taken, so a stalled word holds still.
    always @(negedge i_clk) begin
        t_hole h;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || hole_taken) begin
            if (holes_waiting.size() > 0 &&
                (steady || $urandom_range(99) >= IDLE_PCT)) begin
                h = holes_waiting.pop_front();
                i_valid  <= 1'b1;
                i_hole_x <= h.x;
                i_hole_y <= h.y;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // Monitor: tracks register writes and accepted holes, and checks every
    // motion point that is taken against the oldest point owed.
    always @(posedge i_clk) begin
        t_motion_point pt;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        hole_taken <= i_rst_n && i_valid && !o_stall;
        if (!i_rst_n) begin
            cyc_mode    = 1'b0;
            cyc_depth   = 20'd5000;
            cyc_retract = 20'd2000;
            cyc_peck    = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg'(i_cfg_index))
                    REG_MODE:    cyc_mode    = i_cfg_data[0];
                    REG_DEPTH:   cyc_depth   = i_cfg_data;
                    REG_RETRACT: cyc_retract = i_cfg_data;
                    REG_PECK:    cyc_peck    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                plan_drill_cycle(i_hole_x, i_hole_y);
                holes_accepted++;
            end
            if (o_valid && !i_stall) begin
                if (points_owed.size() == 0) begin
                    $error("motion point with nothing owed: x %0d y %0d z %0d",
                           o_point_x, o_point_y, o_point_z);
                    fault_count++;
                end else begin
                    pt = points_owed.pop_front();
                    if (o_point_x !== pt.x) begin
                        $error("point_x mismatch: expected %0d, actual %0d",
                               pt.x, o_point_x);
                        fault_count++;
                    end
                    if (o_point_y !== pt.y) begin
                        $error("point_y mismatch: expected %0d, actual %0d",
                               pt.y, o_point_y);
                        fault_count++;
                    end
                    if (o_point_z !== pt.z) begin
                        $error("point_z mismatch: expected %0d, actual %0d",
                               pt.z, o_point_z);
                        fault_count++;
                    end
                    if (o_last_point !== pt.last) begin
                        $error("last_point mismatch: expected %0d, actual %0d",
                               pt.last, o_last_point);
                        fault_count++;
                    end
                end
            end
        end
    end

    task automatic write_reg(input t_reg idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        while (1) begin
            @(posedge i_clk);
            if (o_cfg_ready) begin
                break;
            end
        end
    endtask

    // Programs the mode, depth, retract and peck registers. Only called while the block is idle.
    task automatic set_cycle(input logic mode, input logic [CFG_W-1:0] depth,
                             input logic [CFG_W-1:0] lift,
                             input logic [CFG_W-1:0] peck);
        write_reg(REG_MODE, {{(CFG_W-1){1'b0}}, mode});
        write_reg(REG_DEPTH, depth);
        write_reg(REG_RETRACT, lift);
        write_reg(REG_PECK, peck);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        // Holes are queued right after a rising edge, away from the driver.
        @(posedge i_clk);
    endtask

    task automatic queue_hole(input logic signed [XY_W-1:0] hx,
                              input logic signed [XY_W-1:0] hy);
        t_hole h;
        h.x = hx;
        h.y = hy;
        holes_waiting = {holes_waiting, h};
        holes_queued++;
    endtask

    // Waits until every queued hole has been taken and every owed point has
    // come out, then lets the program settle back to idle.
    task automatic drain();
        while (1) begin
            @(negedge i_clk);
            if (holes_accepted == holes_queued && points_owed.size() == 0) begin
                break;
            end
        end
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_depth();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(20000, 1));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_peck();
        case ($urandom_range(5))
            0, 1, 2: return '0;
            3:       return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(5000, 1));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_retract();
        case ($urandom_range(5))
            0:       return '0;
            1:       return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(5000, 0));
        endcase
    endfunction

    function automatic logic signed [XY_W-1:0] pick_coord();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 24'sh7FFFFF;
            2:       return 24'sh800000;
            default: return XY_W'($urandom);
        endcase
    endfunction

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: simple cycle, coordinates at zero, at their extremes and at minus one.
        queue_hole(24'sh000000, 24'sh000000);
        queue_hole(24'sh7FFFFF, 24'sh800000);
        queue_hole(24'sh800000, 24'sh7FFFFF);
        queue_hole(-24'sd1, -24'sd1);
        drain();

        // Default peck step on the reset depth: four even pecks, the last
        // one landing exactly on the bottom.
        set_cycle(1'b1, 20'd5000, 20'd2000, 20'd0);
        queue_hole(24'sh123456, -24'sd654321);
        queue_hole(24'sh555555, 24'shAAAAAA);
        drain();

        // Zero depth in both modes.
        set_cycle(1'b0, 20'd0, 20'd1500, 20'd0);
        queue_hole(24'sd100, 24'sd200);
        drain();
        set_cycle(1'b1, 20'd0, 20'd1500, 20'd0);
        queue_hole(24'sd300, 24'sd400);
        drain();

        // Largest depth and retract with a one-micron peck: the step is
        // widened and the hole takes the full number of pecks.
        set_cycle(1'b1, 20'hFFFFF, 20'hFFFFF, 20'd1);
        queue_hole(24'sh7FFFFF, 24'sh7FFFFF);
        drain();
        // A peck as deep as the whole hole drills it in one peck.
        set_cycle(1'b1, 20'hFFFFF, 20'd0, 20'hFFFFF);
        queue_hole(24'sh800000, 24'sh800000);
        drain();

        // Shallow hole with the default step held at its minimum.
        set_cycle(1'b1, 20'd999, 20'd250, 20'd0);
        queue_hole(-24'sd5, 24'sd5);
        drain();
        // Steps too small to give any re-entry clearance.
        set_cycle(1'b1, 20'd7, 20'd0, 20'd3);
        queue_hole(24'sd1, -24'sd1);
        drain();
        // Uneven pecks ending on a short one.
        set_cycle(1'b1, 20'd10000, 20'd3000, 20'd3000);
        queue_hole(-24'sd777777, 24'sd888888);
        drain();
        // Simple cycle at full depth.
        set_cycle(1'b0, 20'hFFFFF, 20'hFFFFF, 20'd0);
        queue_hole(24'sd42, -24'sd42);
        drain();

        // Random settings, each with a batch of random holes. One phase runs
        // without any idle cycles on either side.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_cycle(1'($urandom_range(1)), pick_depth(), pick_retract(),
                      pick_peck());
            steady = (p == STEADY_PHASE);
            for (int n = 0; n < HOLES_PER_PHASE; n++) begin
                queue_hole(pick_coord(), pick_coord());
            end
            drain();
            steady = 1'b0;
        end

        repeat (20) @(negedge i_clk);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
